>>> hw/rtl/float32_square_root_macros.svh
// Assertion macros shared by the square-root block.
`ifndef FLOAT32_SQUARE_ROOT_MACROS_SVH
`define FLOAT32_SQUARE_ROOT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define FSQ_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked outside reset.
`define FSQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/fsq_pkg.sv
// Package with the constants and types of the square-root pipeline.
package fsq_pkg;

	localparam int unsigned NumSteps  = 25;
	localparam int unsigned StepsPerStage = 5;
	localparam int unsigned NumStages = NumSteps / StepsPerStage;
	localparam int unsigned RemW = 28;

	localparam logic [31:0] ExpMask    = 32'h7f80_0000;
	localparam logic [31:0] QuietBit   = 32'h0040_0000;
	localparam logic [31:0] DefaultNan = 32'h7fc0_0000;
	localparam logic [31:0] HalfBias   = 32'h3f00_0000;

	// Per-item data carried alongside the recurrence.
	typedef struct packed {
		logic        special;
		logic [31:0] spec_root;
		logic        spec_inv;
		logic [7:0]  half;
	} fsq_side_t;

endpackage

>>> hw/rtl/float32_square_root.sv
// Pipelined IEEE-754 single-precision square root, rounded to nearest even.
//
//  Channel | Signals                           | Direction
//  in      | in_valid, in_stall, operand       | beat into the block
//  out     | out_valid, out_stall, root, invalid, inexact | beat out of the block
//
// One beat is accepted per cycle while in_stall is low; the stages are unpack, five
// recurrence stages of five root bits each, round and pack.
// A stall on the output holds the occupied stages back to the first empty stage.
// Bubbles are squeezed out: a stage moves when the stage after it is empty or moving.
// Reset clears only the valid bits.
`include "float32_square_root_macros.svh"
module float32_square_root import fsq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] operand,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] root,
	output logic        invalid,
	output logic        inexact
);

	localparam int unsigned NV = NumStages + 2;

	logic [NV-1:0] vld_q;
	logic [NV-1:0] adv;

	// Stage registers: index 0 is unpack, 1..NumStages recurrence outputs.
	logic [RemW-1:0] rem_q [NumStages+1];
	logic [26:0]     s_q   [NumStages+1];
	logic [25:0]     qt_q  [NumStages+1];
	fsq_side_t       side_q [NumStages+1];
	logic [31:0]     root_q;
	logic            inv_q;
	logic            inx_q;

	// Advance enables from the output backward.
	always_comb begin
		adv[NV-1] = !vld_q[NV-1] || !out_stall;
		for (int i = NV - 2; i >= 0; i--) begin
			adv[i] = !vld_q[i] || adv[i+1];
		end
	end
	assign in_stall = !adv[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) vld_q[0] <= in_valid;
			for (int i = 1; i < NV; i++) begin
				if (adv[i]) vld_q[i] <= vld_q[i-1];
			end
		end
	end

	// Unpack: classify, normalize the significand, halve the exponent.
	logic [31:0] mag;
	logic [22:0] frac;
	logic [4:0]  lz;
	logic [23:0] sig;
	logic [8:0]  ebias;
	logic [24:0] sig2;
	fsq_side_t   side_d;

	always_comb begin
		mag  = {1'b0, operand[30:0]};
		frac = operand[22:0];
		lz   = '0;
		for (int k = 0; k < 23; k++) begin
			if (frac[k]) lz = 5'(22 - k) + 5'd1;
		end
		if (operand[30:23] == 8'd0) begin
			sig   = {1'b0, frac} << lz;
			// e + 256 with e = 1 - lz - 127
			ebias = 9'd130 - 9'(lz);
		end else begin
			sig   = {1'b1, frac};
			ebias = 9'(operand[30:23]) + 9'd129;
		end
		sig2 = ebias[0] ? {sig, 1'b0} : {1'b0, sig};
		side_d.half      = 8'(ebias[8:1] - 8'd128);
		side_d.special   = 1'b1;
		side_d.spec_inv  = 1'b0;
		side_d.spec_root = operand;
		if (mag == 32'd0) begin
			side_d.spec_root = operand;
		end else if (operand[31]) begin
			if (mag > ExpMask) begin
				side_d.spec_root = operand | QuietBit;
			end else begin
				side_d.spec_root = DefaultNan;
				side_d.spec_inv  = 1'b1;
			end
		end else if ((operand & ExpMask) == ExpMask) begin
			side_d.spec_root = operand;
		end else begin
			side_d.special = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			rem_q[0]  <= RemW'({sig2, 1'b0});
			s_q[0]    <= '0;
			qt_q[0]   <= '0;
			side_q[0] <= side_d;
		end
	end

	// Recurrence stages, five root bits each.
	for (genvar g = 0; g < NumStages; g++) begin : g_rec
		logic [RemW-1:0] r;
		logic [26:0]     s;
		logic [25:0]     q;
		logic [26:0]     b;
		logic [26:0]     t;
		always_comb begin
			r = rem_q[g];
			s = s_q[g];
			q = qt_q[g];
			for (int k = 0; k < StepsPerStage; k++) begin
				b = 27'(1) << (NumSteps - 1 - g * StepsPerStage - k);
				t = s + b;
				if (RemW'(t) <= r) begin
					s = t + b;
					r = r - RemW'(t);
					q = q | b[25:0];
				end
				r = r << 1;
			end
		end
		always_ff @(posedge clk) begin
			if (adv[g+1]) begin
				rem_q[g+1]  <= r;
				s_q[g+1]    <= s;
				qt_q[g+1]   <= q;
				side_q[g+1] <= side_q[g];
			end
		end
	end

	// Round to nearest even and pack; the halved exponent is sign-extended.
	logic        rnz;
	logic [25:0] qr;
	logic [31:0] res;
	fsq_side_t   sd;
	always_comb begin
		sd  = side_q[NumStages];
		rnz = rem_q[NumStages] != '0;
		qr  = qt_q[NumStages] + (rnz ? 26'(qt_q[NumStages][0]) : 26'd0);
		res = 32'(qr[25:1]) + HalfBias + ({{24{sd.half[7]}}, sd.half} << 23);
	end

	always_ff @(posedge clk) begin
		if (adv[NV-1]) begin
			root_q <= sd.special ? sd.spec_root : res;
			inv_q  <= sd.special & sd.spec_inv;
			inx_q  <= !sd.special & rnz;
		end
	end

	assign out_valid = vld_q[NV-1];
	assign root      = root_q;
	assign invalid   = inv_q;
	assign inexact   = inx_q;

	`FSQ_ASSERT_IMP(a_flags_excl, out_valid, !(invalid && inexact), "invalid and inexact together")
	`FSQ_ASSERT_IMP(a_inv_nan, out_valid && invalid, root == DefaultNan, "invalid without NaN")
	`FSQ_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(root), "stalled beat moved")

endmodule
